### design/dtw_pkg.sv
package dtw_pkg;

   // Grid limits and request width
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 64;
   localparam int COST_BITS   = 16;

   // Fixed field widths
   localparam int LEN_W   = 7;
   localparam int TOTAL_W = 23;
   localparam int SCORE_W = 20;

   // Grid index widths and the widths used to compare them with a length
   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_CMP_W = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;
   localparam int ROW_CMP_W = (ROW_W + 1 > LEN_W) ? ROW_W + 1 : LEN_W;
   localparam int LOCAL_W   = (COST_BITS > TOTAL_W) ? COST_BITS : TOTAL_W;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LENGTH_A = 1'b0;
   localparam logic REG_LENGTH_B = 1'b1;

   // Size penalty: round(256 * exp(d / 10))
   localparam int PENALTY_ENTRIES = 84;
   localparam logic [SCORE_W-1:0] PENALTY_ROM [PENALTY_ENTRIES] = '{
      20'd256, 20'd283, 20'd313, 20'd346, 20'd382, 20'd422, 20'd466, 20'd516,
      20'd570, 20'd630, 20'd696, 20'd769, 20'd850, 20'd939, 20'd1038, 20'd1147,
      20'd1268, 20'd1401, 20'd1549, 20'd1712, 20'd1892, 20'd2091, 20'd2310,
      20'd2553, 20'd2822, 20'd3119, 20'd3447, 20'd3809, 20'd4210, 20'd4653,
      20'd5142, 20'd5683, 20'd6280, 20'd6941, 20'd7671, 20'd8478, 20'd9369,
      20'd10355, 20'd11444, 20'd12647, 20'd13977, 20'd15447, 20'd17072,
      20'd18867, 20'd20851, 20'd23044, 20'd25468, 20'd28146, 20'd31107,
      20'd34378, 20'd37994, 20'd41990, 20'd46406, 20'd51286, 20'd56680,
      20'd62641, 20'd69229, 20'd76510, 20'd84557, 20'd93450, 20'd103278,
      20'd114140, 20'd126144, 20'd139410, 20'd153816, 20'd170020, 20'd188184,
      20'd207976, 20'd229849, 20'd254022, 20'd280738, 20'd310008, 20'd342894,
      20'd378957, 20'd419068, 20'd462859, 20'd511538, 20'd565337, 20'd624794,
      20'd690504, 20'd763125, 20'd843384, 20'd932083, 20'd1030111
   };

   // Accumulated cost and path length of one cell
   typedef struct packed {
      logic [TOTAL_W-1:0] cost;
      logic [LEN_W-1:0]   len;
   } path_entry_type;

   // Control of the cell in the update stage
   typedef struct packed {
      logic             valid;
      logic             first_row;
      logic             first_col;
      logic             last;
      logic [COL_W-1:0] col;
   } cell_ctl_type;

   // Treat zero as one, cap at the grid limit
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                  input int lim);
      logic [LEN_W-1:0] r;
      r = v;
      if (v == '0) r = LEN_W'(1);
      else if (int'(v) > lim) r = LEN_W'(lim);
      return r;
   endfunction

   // Saturate the request cost into the accumulator range
   function automatic logic [TOTAL_W-1:0] sat_local(input logic [COST_BITS-1:0] v);
      logic [LOCAL_W-1:0] ext;
      logic [TOTAL_W-1:0] r;
      ext = LOCAL_W'(v);
      if (ext > LOCAL_W'(TOTAL_MAX)) r = TOTAL_MAX;
      else r = ext[TOTAL_W-1:0];
      return r;
   endfunction

   // Look up the size penalty, saturate past the table
   function automatic logic [SCORE_W-1:0] penalty(input logic [LEN_W-1:0] d);
      logic [SCORE_W-1:0] r;
      r = SCORE_MAX;
      if (int'(d) < PENALTY_ENTRIES) r = PENALTY_ROM[d];
      return r;
   endfunction

endpackage

### design/dtw_row_mem.sv
module dtw_row_mem
   import dtw_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output path_entry_type   rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  path_entry_type   wr_data
);

   path_entry_type mem [MAX_COLUMNS];
   path_entry_type rd_data_ff;

   // Write the current row's result
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the previous row's entry, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dtw_cell.sv
module dtw_cell
   import dtw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [TOTAL_W-1:0] local_cost,
   input  path_entry_type     up,
   output path_entry_type     result
);

   path_entry_type left_ff, left_in;
   path_entry_type diag_ff, diag_in;
   path_entry_type base;
   logic [TOTAL_W:0] cost_sum;

   // Pick the cheapest neighbor, diagonal first, then up
   always_comb begin
      if (ctl.first_row && ctl.first_col) begin
         base = '0;
      end else if (ctl.first_row) begin
         base = left_ff;
      end else if (ctl.first_col) begin
         base = up;
      end else if (diag_ff.cost <= up.cost && diag_ff.cost <= left_ff.cost) begin
         base = diag_ff;
      end else if (up.cost <= left_ff.cost) begin
         base = up;
      end else begin
         base = left_ff;
      end
   end

   // Accumulate with saturation
   always_comb begin
      cost_sum = {1'b0, base.cost} + {1'b0, local_cost};
      result.cost = cost_sum[TOTAL_W] ? TOTAL_MAX : cost_sum[TOTAL_W-1:0];
      result.len  = (base.len == LEN_MAX) ? LEN_MAX : base.len + LEN_W'(1);
   end

   // Advance the left and diagonal neighbors
   always_comb begin
      left_in = left_ff;
      diag_in = diag_ff;
      if (ctl.valid) begin
         left_in = result;
         diag_in = up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else begin
         left_ff <= left_in;
         diag_ff <= diag_in;
      end
   end

endmodule

### design/dtw_div.sv
module dtw_div
   import dtw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  path_entry_type     last_cell,
   input  logic [LEN_W-1:0]   rows,
   input  logic [LEN_W-1:0]   cols,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SCORE_W-1:0] rsp_score,
   output logic [TOTAL_W-1:0] rsp_total_cost,
   output logic [LEN_W-1:0]   rsp_path_length
);

   localparam int CNT_W = $clog2(TOTAL_W + 1);
   localparam logic [1:0] DIV_IDLE = 2'd0;
   localparam logic [1:0] DIV_RUN  = 2'd1;
   localparam logic [1:0] DIV_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] quot_ff, quot_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   divisor_ff, divisor_in;
   logic [TOTAL_W-1:0] cost_ff, cost_in;
   logic [SCORE_W-1:0] pen_ff, pen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   logic [LEN_W-1:0]   diff;
   logic [LEN_W:0]     trial;
   logic [LEN_W:0]     trial_sub;
   logic               trial_ge;
   logic [SCORE_W-1:0] quot_sat;
   logic [SCORE_W:0]   score_sum;
   logic               load_rsp;

   // Length difference for the penalty lookup
   assign diff = (rows > cols) ? rows - cols : cols - rows;

   // One restoring division step
   always_comb begin
      trial     = {rem_ff, quot_ff[TOTAL_W-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      trial_ge  = trial >= {1'b0, divisor_ff};
   end

   // Saturate the quotient, add the penalty
   always_comb begin
      quot_sat  = (quot_ff > TOTAL_W'(SCORE_MAX)) ? SCORE_MAX : quot_ff[SCORE_W-1:0];
      score_sum = {1'b0, quot_sat} + {1'b0, pen_ff};
   end

   assign load_rsp = (state_ff == DIV_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequence the division
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cost_in    = cost_ff;
      pen_in     = pen_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               quot_in    = last_cell.cost;
               cost_in    = last_cell.cost;
               divisor_in = last_cell.len;
               rem_in     = '0;
               pen_in     = penalty(diff);
               cnt_in     = CNT_W'(TOTAL_W);
               state_in   = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in  = trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
            quot_in = {quot_ff[TOTAL_W-2:0], trial_ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (load_rsp) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Hold the result until the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_total_in = rsp_total_ff;
      rsp_len_in   = rsp_len_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
         rsp_total_in = cost_ff;
         rsp_len_in   = divisor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      cost_ff      <= cost_in;
      pen_ff       <= pen_in;
      rsp_score_ff <= rsp_score_in;
      rsp_total_ff <= rsp_total_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign busy            = (state_ff != DIV_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_total_cost  = rsp_total_ff;
   assign rsp_path_length = rsp_len_ff;

endmodule

### design/dtw_path_normalized_distance.sv
// Channel   | Direction | Handshake                         | Payload
// request   | in        | req_valid / req_ready             | req_local_cost
// response  | out       | rsp_valid / rsp_ready             | score, total_cost, path_length
// csr       | in/out    | csr_psel, csr_penable, csr_pready | length_a, length_b
//
// One grid cell per clock while req_ready is high: a request reads the previous row's
// entry from the row memory, and the next cycle adds the cheapest neighbor and writes
// the entry back. After the last cell requests stall through the update stage, 23
// divider steps and the load of the response. A response still waiting at that
// point holds the divider and keeps requests stalled until it is taken.
// Synchronous active-high reset; the row memory needs no clearing pass.
module dtw_path_normalized_distance
   import dtw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COST_BITS-1:0]  req_local_cost,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SCORE_W-1:0]    rsp_score,
   output logic [TOTAL_W-1:0]    rsp_total_cost,
   output logic [LEN_W-1:0]      rsp_path_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0]   length_a_ff, length_a_in;
   logic [LEN_W-1:0]   length_b_ff, length_b_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   cell_ctl_type       ctl_ff, ctl_in;
   logic [TOTAL_W-1:0] local_ff;
   logic               fwd_ff, fwd_in;
   path_entry_type     fwd_data_ff;

   logic               csr_write;
   logic               reg_sel;
   logic [LEN_W-1:0]   rows;
   logic [LEN_W-1:0]   cols;
   logic               accept;
   logic               div_busy;
   logic [COL_CMP_W-1:0] col_next;
   logic [ROW_CMP_W-1:0] row_next;
   logic               col_wrap;
   logic               row_wrap;
   path_entry_type     rd_data;
   path_entry_type     up;
   path_entry_type     result;

   // Decode register writes
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_sel == REG_LENGTH_B) ? CSR_DATA_W'(length_b_ff)
                                                 : CSR_DATA_W'(length_a_ff);

   always_comb begin
      length_a_in = length_a_ff;
      length_b_in = length_b_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_LENGTH_A: length_a_in = csr_pwdata[LEN_W-1:0];
            REG_LENGTH_B: length_b_in = csr_pwdata[LEN_W-1:0];
            default:      length_a_in = length_a_ff;
         endcase
      end
   end

   assign rows = clamp_len(length_a_ff, MAX_ROWS);
   assign cols = clamp_len(length_b_ff, MAX_COLUMNS);

   // Stall while the divider works or the last cell is in the update stage
   assign req_ready = !div_busy && !(ctl_ff.valid && ctl_ff.last);
   assign accept    = req_valid && req_ready;

   // Advance the grid position; a register write restarts the grid
   always_comb begin
      col_next = COL_CMP_W'(col_ff) + COL_CMP_W'(1);
      row_next = ROW_CMP_W'(row_ff) + ROW_CMP_W'(1);
      col_wrap = col_next >= COL_CMP_W'(cols);
      row_wrap = row_next >= ROW_CMP_W'(rows);
      col_in   = col_ff;
      row_in   = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // Tag the request for the update stage
   always_comb begin
      ctl_in.valid     = accept;
      ctl_in.first_row = (row_ff == '0);
      ctl_in.first_col = (col_ff == '0);
      ctl_in.last      = col_wrap && row_wrap;
      ctl_in.col       = col_ff;
   end

   // Forward the entry being written when the new request reads the same column
   assign fwd_in = accept && ctl_ff.valid && (ctl_ff.col == col_ff);
   assign up     = fwd_ff ? fwd_data_ff : rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_a_ff <= LEN_W'(1);
         length_b_ff <= LEN_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         ctl_ff      <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         length_a_ff <= length_a_in;
         length_b_ff <= length_b_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         ctl_ff      <= ctl_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         local_ff <= sat_local(req_local_cost);
      end
      fwd_data_ff <= result;
   end

   dtw_row_mem u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (ctl_ff.valid),
      .wr_addr (ctl_ff.col),
      .wr_data (result)
   );

   dtw_cell u_cell (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_ff),
      .local_cost (local_ff),
      .up         (up),
      .result     (result)
   );

   dtw_div u_div (
      .clock           (clock),
      .reset           (reset),
      .start           (ctl_ff.valid && ctl_ff.last),
      .last_cell       (result),
      .rows            (rows),
      .cols            (cols),
      .busy            (div_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_score       (rsp_score),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_path_length (rsp_path_length)
   );

endmodule

### design/dtw_checker.sv
module dtw_checker
   import dtw_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SCORE_W-1:0] rsp_score,
   input logic [TOTAL_W-1:0] rsp_total_cost,
   input logic [LEN_W-1:0]   rsp_path_length
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score)
         && $stable(rsp_total_cost) && $stable(rsp_path_length))
      else $error("stalled response changed");

   // Path covers at least one cell and the score carries the penalty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_path_length != '0 && rsp_score >= PENALTY_ROM[0])
      else $error("response out of range");

   // Drop the response on reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A new response comes only from a grid end, while requests were stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without stalled requests");

endmodule

bind dtw_path_normalized_distance dtw_checker u_dtw_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import dtw_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;

   // Size penalty per length difference: round(256 * exp(d / 10))
   localparam int unsigned PENALTY_DEPTH = 84;
   localparam int unsigned SIZE_PENALTY [PENALTY_DEPTH] = '{
      256, 283, 313, 346, 382, 422, 466, 516, 570, 630,
      696, 769, 850, 939, 1038, 1147, 1268, 1401, 1549, 1712,
      1892, 2091, 2310, 2553, 2822, 3119, 3447, 3809, 4210, 4653,
      5142, 5683, 6280, 6941, 7671, 8478, 9369, 10355, 11444, 12647,
      13977, 15447, 17072, 18867, 20851, 23044, 25468, 28146, 31107, 34378,
      37994, 41990, 46406, 51286, 56680, 62641, 69229, 76510, 84557, 93450,
      103278, 114140, 126144, 139410, 153816, 170020, 188184, 207976, 229849, 254022,
      280738, 310008, 342894, 378957, 419068, 462859, 511538, 565337, 624794, 690504,
      763125, 843384, 932083, 1030111
   };

   typedef enum {COST_NARROW, COST_WIDE, COST_CORNER} cost_mode_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TOTAL_W-1:0] total_cost;
      logic [LEN_W-1:0]   path_length;
   } grid_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [COST_BITS-1:0]  req_local_cost;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SCORE_W-1:0]    rsp_score;
   logic [TOTAL_W-1:0]    rsp_total_cost;
   logic [LEN_W-1:0]      rsp_path_length;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int req_idle_pct;
   int rsp_stall_pct;
   int error_count = 0;
   int request_count;
   int cycle_count = 0;

   // Predicted grid state
   logic [LEN_W-1:0]   model_length_a;
   logic [LEN_W-1:0]   model_length_b;
   logic [TOTAL_W-1:0] prev_row_cost [MAX_COLUMNS];
   logic [LEN_W-1:0]   prev_row_len [MAX_COLUMNS];
   logic [TOTAL_W-1:0] left_cost;
   logic [LEN_W-1:0]   left_len;
   logic [TOTAL_W-1:0] diag_cost;
   logic [LEN_W-1:0]   diag_len;
   int unsigned        cur_row;
   int unsigned        cur_col;
   grid_result_type    expected_scores [$];

   dtw_path_normalized_distance DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_local_cost  (req_local_cost),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_score       (rsp_score),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_path_length (rsp_path_length),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   // Zero means one, anything past the limit means the limit
   function automatic int unsigned grid_extent(input logic [LEN_W-1:0] v,
                                               input int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic clear_grid_model();
      model_length_a = LEN_W'(1);
      model_length_b = LEN_W'(1);
      for (int k = 0; k < MAX_COLUMNS; k++) begin
         prev_row_cost[k] = '0;
         prev_row_len[k]  = '0;
      end
      left_cost = '0;
      left_len  = '0;
      diag_cost = '0;
      diag_len  = '0;
      cur_row   = 0;
      cur_col   = 0;
   endtask

   // Advance the grid by one request; queue the result after the last cell
   task automatic accumulate_cell(input logic [COST_BITS-1:0] local_cost);
      int unsigned  rows, cols, col, size_gap, quotient, penalty_value, sum;
      logic [TOTAL_W-1:0] up_cost, base_cost, new_cost;
      logic [LEN_W-1:0]   up_len, base_len, new_len;
      grid_result_type    result;
      rows    = grid_extent(model_length_a, MAX_ROWS);
      cols    = grid_extent(model_length_b, MAX_COLUMNS);
      col     = cur_col % MAX_COLUMNS;
      up_cost = prev_row_cost[col];
      up_len  = prev_row_len[col];
      // Pick the cheapest predecessor: diagonal first, then up, then left
      if (cur_row == 0 && col == 0) begin
         base_cost = '0;
         base_len  = '0;
      end else if (cur_row == 0) begin
         base_cost = left_cost;
         base_len  = left_len;
      end else if (col == 0) begin
         base_cost = up_cost;
         base_len  = up_len;
      end else if (diag_cost <= up_cost && diag_cost <= left_cost) begin
         base_cost = diag_cost;
         base_len  = diag_len;
      end else if (up_cost <= left_cost) begin
         base_cost = up_cost;
         base_len  = up_len;
      end else begin
         base_cost = left_cost;
         base_len  = left_len;
      end
      sum      = int'(base_cost) + int'(local_cost);
      new_cost = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
      new_len  = (base_len == LEN_MAX) ? LEN_MAX : base_len + LEN_W'(1);

      diag_cost          = up_cost;
      diag_len           = up_len;
      prev_row_cost[col] = new_cost;
      prev_row_len[col]  = new_len;
      left_cost          = new_cost;
      left_len           = new_len;

      cur_col = col + 1;
      if (cur_col >= cols) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= rows) begin
            cur_row       = 0;
            size_gap      = (rows > cols) ? rows - cols : cols - rows;
            penalty_value = (size_gap < PENALTY_DEPTH) ? SIZE_PENALTY[size_gap] : SCORE_MAX;
            quotient      = new_cost / ((new_len == '0) ? LEN_W'(1) : new_len);
            if (quotient > SCORE_MAX) quotient = SCORE_MAX;
            sum = quotient + penalty_value;
            result.score       = (sum > SCORE_MAX) ? SCORE_MAX : SCORE_W'(sum);
            result.total_cost  = new_cost;
            result.path_length = new_len;
            expected_scores = {expected_scores, result};
         end
      end
   endtask

   // Track register writes, check reads, predict and compare results
   always @(posedge clock) begin
      grid_result_type want;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         clear_grid_model();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_LENGTH_A: reg_value = CSR_DATA_W'(model_length_a);
               REG_LENGTH_B: reg_value = CSR_DATA_W'(model_length_b);
               default:      reg_value = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr[CSR_ADDR_W-1:2])
                  REG_LENGTH_A: model_length_a = csr_pwdata[LEN_W-1:0];
                  REG_LENGTH_B: model_length_b = csr_pwdata[LEN_W-1:0];
                  default: ;
               endcase
               cur_row = 0;
               cur_col = 0;
            end else if (csr_prdata !== reg_value) begin
               report_mismatch($sformatf("register read at %0d: got %0d, expected %0d",
                                         csr_paddr, csr_prdata, reg_value));
            end
         end
         if (req_valid && req_ready) accumulate_cell(req_local_cost);
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               report_mismatch($sformatf("unexpected result: score %0d cost %0d length %0d",
                                         rsp_score, rsp_total_cost, rsp_path_length));
            end else begin
               want = expected_scores.pop_front();
               if (rsp_score !== want.score)
                  report_mismatch($sformatf("score: got %0d, expected %0d",
                                            rsp_score, want.score));
               if (rsp_total_cost !== want.total_cost)
                  report_mismatch($sformatf("total_cost: got %0d, expected %0d",
                                            rsp_total_cost, want.total_cost));
               if (rsp_path_length !== want.path_length)
                  report_mismatch($sformatf("path_length: got %0d, expected %0d",
                                            rsp_path_length, want.path_length));
            end
         end
      end
   end

   // Present one request, hold it until accepted
   task automatic send_request(input logic [COST_BITS-1:0] cost);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_local_cost <= cost;
      do @(posedge clock); while (!req_ready);
      request_count++;
   endtask

   function automatic logic [COST_BITS-1:0] pick_cost(input cost_mode_type mode);
      logic [COST_BITS-1:0] bit_mask;
      logic [COST_BITS-1:0] cost;
      bit_mask = COST_BITS'(1) << $urandom_range(COST_BITS - 1);
      case (mode)
         COST_NARROW: cost = COST_BITS'($urandom_range(3));
         COST_WIDE:   cost = COST_BITS'($urandom());
         default: begin
            case ($urandom_range(3))
               0:       cost = '0;
               1:       cost = '1;
               2:       cost = bit_mask;
               default: cost = ~bit_mask;
            endcase
         end
      endcase
      return cost;
   endfunction

   task automatic send_costs(input int unsigned count, input cost_mode_type mode);
      repeat (count) send_request(pick_cost(mode));
   endtask

   // Drop valid, drain expected results, let the divider finish
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a length register once idle, then read it back
   task automatic write_length(input logic reg_sel, input logic [LEN_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      if ($urandom_range(3) != 0) data = '0;
      data[LEN_W-1:0] = value;
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Reset size is one by one: each request closes a grid
   task test_single_cell();
      send_request('0);
      send_request('1);
      send_request(COST_BITS'(16'h5A5A));
   endtask

   // All-zero grid takes the diagonal; a costly center makes up win its tie with left
   task automatic test_tie_breaks();
      write_length(REG_LENGTH_A, LEN_W'(3));
      write_length(REG_LENGTH_B, LEN_W'(3));
      repeat (9) send_request('0);
      for (int k = 0; k < 9; k++)
         send_request((k == 4) ? COST_BITS'(9) : (k == 8) ? COST_BITS'(5) : '0);
   endtask

   // Partial grids are dropped by writes to either register
   task test_grid_restart();
      write_length(REG_LENGTH_A, LEN_W'(3));
      write_length(REG_LENGTH_B, LEN_W'(2));
      send_costs(3, COST_WIDE);
      write_length(REG_LENGTH_A, LEN_W'(3));
      send_costs(1, COST_WIDE);
      write_length(REG_LENGTH_B, LEN_W'(2));
      send_costs(6, COST_CORNER);
   endtask

   // Clamped lengths at both limits give the widest size difference
   task automatic test_grid_extremes();
      write_length(REG_LENGTH_A, LEN_W'(0));
      write_length(REG_LENGTH_B, LEN_W'(127));
      send_costs(MAX_COLUMNS, COST_CORNER);
      write_length(REG_LENGTH_A, LEN_W'(127));
      write_length(REG_LENGTH_B, LEN_W'(0));
      send_costs(MAX_ROWS, COST_WIDE);
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return LEN_W'($urandom_range(6, 1));
      if (r < 85) return LEN_W'($urandom_range(16, 7));
      if (r < 92) return LEN_W'($urandom_range(64, 17));
      if (r < 96) return '0;
      return LEN_W'($urandom_range(127, 65));
   endfunction

   // Random sizes, a grid or two per size, now and then a dropped partial grid
   task automatic test_random_grids(input int min_requests, input int min_grids);
      int               start_count;
      int               grid_count;
      int unsigned      cell_total;
      logic [LEN_W-1:0] rows_value;
      logic [LEN_W-1:0] cols_value;
      start_count = request_count;
      grid_count  = 0;
      while (request_count - start_count < min_requests || grid_count < min_grids) begin
         rows_value = pick_length();
         cols_value = pick_length();
         while (grid_extent(rows_value, MAX_ROWS) * grid_extent(cols_value, MAX_COLUMNS) > 64)
            cols_value = LEN_W'($urandom_range(4, 1));
         cell_total = grid_extent(rows_value, MAX_ROWS) * grid_extent(cols_value, MAX_COLUMNS);
         if ($urandom_range(1)) begin
            write_length(REG_LENGTH_A, rows_value);
            write_length(REG_LENGTH_B, cols_value);
         end else begin
            write_length(REG_LENGTH_B, cols_value);
            write_length(REG_LENGTH_A, rows_value);
         end
         repeat ($urandom_range(2, 1)) begin
            send_costs(cell_total, cost_mode_type'($urandom_range(2)));
            grid_count++;
         end
         if (cell_total > 1 && $urandom_range(5) == 0)
            send_costs($urandom_range(cell_total - 1, 1), COST_WIDE);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_local_cost = '0;
      rsp_ready      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      request_count  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_single_cell();
      test_tie_breaks();
      test_grid_restart();
      test_grid_extremes();

      // Sweep the idling mixes
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_grids(40, 3);
      req_idle_pct  = 87;
      rsp_stall_pct = 0;
      test_random_grids(40, 3);
      req_idle_pct  = 0;
      rsp_stall_pct = 87;
      test_random_grids(40, 3);
      req_idle_pct  = 19;
      rsp_stall_pct = 19;
      test_random_grids(40, 3);

      settle();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
